@@ hdl/wac_pkg.sv @@
// ----------------------------------------------------------------------------
// wac_pkg
// Shared types and constants of the word autokey stream cipher: key reset
// values, configuration register indexes, key schedule constants and the
// result word layout.
// ----------------------------------------------------------------------------
package wac_pkg;

   localparam int WORD_W    = 32;
   localparam int TBL_DEPTH = 257;
   localparam int TBL_AW    = 9;
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_KEY0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 3'd4;

   // Key words after reset.
   localparam logic [WORD_W-1:0] KEY0_RST = 32'hCEF2_F7E0;
   localparam logic [WORD_W-1:0] KEY1_RST = 32'hFFED_E8E5;
   localparam logic [WORD_W-1:0] KEY2_RST = 32'h20C2_E0EC;
   localparam logic [WORD_W-1:0] KEY3_RST = 32'hEFE8_F0E0;

   // Key schedule constants.
   localparam logic [WORD_W-1:0] SCR_OR_MASK  = 32'h0100_0001;
   localparam logic [WORD_W-1:0] SCR_AND_MASK = 32'hFF7F_FFFF;
   localparam logic [WORD_W-1:0] LOW24_MASK   = 32'h00FF_FFFF;
   localparam logic [TBL_AW-1:0] ADD_OFS      = 9'd89;
   localparam logic [7:0]        ADD_LAST     = 8'd22;
   localparam logic [TBL_AW-1:0] SCR_X_ADDR   = 9'd33;
   localparam logic [TBL_AW-1:0] SCR_Z_ADDR   = 9'd59;
   localparam logic [TBL_AW-1:0] WRAP_ADDR    = 9'd256;
   localparam logic [7:0]        IDX_LAST     = 8'hFF;

   typedef struct packed {
      logic [WORD_W-1:0] result_word;
      logic [WORD_W-1:0] reg_a;
      logic [WORD_W-1:0] reg_b;
      logic [WORD_W-1:0] reg_c;
      logic [WORD_W-1:0] reg_d;
   } rsp_word_type;

   function automatic logic [WORD_W-1:0] seed_const(input logic [2:0] sel);
      logic [WORD_W-1:0] val;
      case (sel)
         3'd0:    val = 32'h726A_8F3B;
         3'd1:    val = 32'hE69A_3B5C;
         3'd2:    val = 32'hD3C7_1FE5;
         3'd3:    val = 32'hAB3C_73D2;
         3'd4:    val = 32'h4D3A_8EB3;
         3'd5:    val = 32'h0396_D6E8;
         3'd6:    val = 32'h3D4C_2F7A;
         default: val = 32'h9EE2_7CF3;
      endcase
      return val;
   endfunction

endpackage

@@ hdl/wake_autokey_stream_cipher.sv @@
// ----------------------------------------------------------------------------
// wake_autokey_stream_cipher
// Word autokey stream cipher: a 257-word mixing table built from the key in
// a synchronous memory with one write and one read port, and four running
// registers advanced by four chained table lookups per word.
// ----------------------------------------------------------------------------
// Usage:
// Words enter on the req_ channel and each yields one result word on the rsp_
// channel, together with the four running registers after that word. A word
// with req_first_word set reloads the running registers from the key first.
// The csr_ port writes the four key words and the decrypt mode bit.
// A key write starts a rebuild of the mixing table; req_stall stays high
// during the rebuild. Reset also runs the rebuild.
// Each word needs four dependent lookups in the table memory, which serves
// one read per cycle; the next word starts with the last lookup of the one
// before, once the output register can take that word's result.
// One input word is buffered while the engine runs, and the result waits in
// an output register. While rsp_stall holds a result, the engine finishes the
// next word up to its last lookup and then waits; input is taken until the
// input buffer is full.
// ----------------------------------------------------------------------------
module wake_autokey_stream_cipher
   import wac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_W-1:0]    req_data_word,
   input  logic                 req_first_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_W-1:0]    rsp_result_word,
   output logic [WORD_W-1:0]    rsp_running_reg_a,
   output logic [WORD_W-1:0]    rsp_running_reg_b,
   output logic [WORD_W-1:0]    rsp_running_reg_c,
   output logic [WORD_W-1:0]    rsp_running_reg_d,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   // Table build phases.
   localparam logic [2:0] PH_SEED  = 3'd0;
   localparam logic [2:0] PH_ADD   = 3'd1;
   localparam logic [2:0] PH_XPREP = 3'd2;
   localparam logic [2:0] PH_XMIX  = 3'd3;
   localparam logic [2:0] PH_WRAP  = 3'd4;
   localparam logic [2:0] PH_SHUF  = 3'd5;
   localparam logic [2:0] PH_RUN   = 3'd6;

   // Lookup whose data returns in the current cycle.
   localparam logic [1:0] STG_A = 2'd0;
   localparam logic [1:0] STG_B = 2'd1;
   localparam logic [1:0] STG_C = 2'd2;
   localparam logic [1:0] STG_D = 2'd3;

   // Table memory.
   logic [WORD_W-1:0] tbl_mem [0:TBL_DEPTH-1];
   logic [WORD_W-1:0] rd_ff;
   logic              mem_we;
   logic [TBL_AW-1:0] mem_wa;
   logic [WORD_W-1:0] mem_wd;
   logic              mem_re;
   logic [TBL_AW-1:0] mem_ra;

   // Configuration and build sequencer.
   logic [WORD_W-1:0] key_ff [0:3];
   logic [WORD_W-1:0] key_in [0:3];
   logic              mode_ff, mode_in;
   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        idx_ff, idx_in;
   logic [2:0]        sub_ff, sub_in;
   logic [WORD_W-1:0] hist_ff [0:3];
   logic [WORD_W-1:0] hist_in [0:3];
   logic [WORD_W-1:0] tmp_ff, tmp_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] z_ff, z_in;
   logic [7:0]        sel_ff, sel_in;
   logic [WORD_W-1:0] seed_sum, seed_val, mix_x, xmix_wd;
   logic              bld_we;
   logic [TBL_AW-1:0] bld_wa, bld_ra;
   logic [WORD_W-1:0] bld_wd;

   // Cipher engine.
   logic              busy_ff, busy_in;
   logic [1:0]        stg_ff, stg_in;
   logic [WORD_W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [WORD_W-1:0] s_ff, s_in, res_ff, res_in;
   logic              in_full_ff, in_full_in;
   logic [WORD_W-1:0] in_data_ff, in_data_in;
   logic              in_first_ff, in_first_in;
   logic              out_valid_ff, out_valid_in;
   rsp_word_type      out_ff, out_in;
   logic              run, at_d, out_ok, start, in_accept;
   logic [WORD_W-1:0] look, base, a_cur, d_cur, res, feed, s_start, s_chain;
   logic              cph_re;
   logic [TBL_AW-1:0] cph_ra;

   // ------------------------------------------------------------------------
   // Memory: one write and one registered read per cycle.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= tbl_mem[mem_ra];
      end
   end

   assign run    = (phase_ff == PH_RUN);
   assign mem_we = run ? 1'b0 : bld_we;
   assign mem_wa = bld_wa;
   assign mem_wd = bld_wd;
   assign mem_re = run ? cph_re : 1'b1;
   assign mem_ra = run ? cph_ra : bld_ra;

   // ------------------------------------------------------------------------
   // Key schedule sequencer and configuration writes.
   // ------------------------------------------------------------------------
   assign seed_sum = hist_ff[0] + hist_ff[3];
   assign seed_val = (idx_ff < 8'd4) ? key_ff[idx_ff[1:0]]
                   : ({3'b000, seed_sum[WORD_W-1:3]} ^ seed_const(seed_sum[2:0]));
   assign mix_x    = (x_ff & SCR_AND_MASK) + z_ff;
   assign xmix_wd  = (rd_ff & LOW24_MASK) ^ mix_x;

   always_comb begin
      bld_we   = 1'b0;
      bld_wa   = {1'b0, idx_ff};
      bld_wd   = '0;
      bld_ra   = {1'b0, idx_ff};
      phase_in = phase_ff;
      idx_in   = idx_ff;
      sub_in   = sub_ff;
      hist_in  = hist_ff;
      tmp_in   = tmp_ff;
      x_in     = x_ff;
      z_in     = z_ff;
      sel_in   = sel_ff;
      key_in   = key_ff;
      mode_in  = mode_ff;

      unique case (phase_ff)
         PH_SEED: begin
            // Keep the last four entries so the fill needs no reads.
            bld_we     = 1'b1;
            bld_wd     = seed_val;
            hist_in[0] = hist_ff[1];
            hist_in[1] = hist_ff[2];
            hist_in[2] = hist_ff[3];
            hist_in[3] = seed_val;
            if (idx_ff == IDX_LAST) begin
               phase_in = PH_ADD;
               idx_in   = '0;
               sub_in   = '0;
            end else begin
               idx_in = idx_ff + 8'd1;
            end
         end
         PH_ADD: begin
            unique case (sub_ff)
               3'd0: begin
                  bld_ra = {1'b0, idx_ff} + ADD_OFS;
                  sub_in = 3'd1;
               end
               3'd1: begin
                  tmp_in = rd_ff;
                  sub_in = 3'd2;
               end
               default: begin
                  bld_we = 1'b1;
                  bld_wd = rd_ff + tmp_ff;
                  sub_in = 3'd0;
                  if (idx_ff == ADD_LAST) begin
                     phase_in = PH_XPREP;
                     idx_in   = '0;
                  end else begin
                     idx_in = idx_ff + 8'd1;
                  end
               end
            endcase
         end
         PH_XPREP: begin
            unique case (sub_ff)
               3'd0: begin
                  bld_ra = SCR_X_ADDR;
                  sub_in = 3'd1;
               end
               3'd1: begin
                  bld_ra = SCR_Z_ADDR;
                  x_in   = rd_ff;
                  sub_in = 3'd2;
               end
               default: begin
                  z_in     = (rd_ff | SCR_OR_MASK) & SCR_AND_MASK;
                  phase_in = PH_XMIX;
                  sub_in   = 3'd0;
               end
            endcase
         end
         PH_XMIX: begin
            unique case (sub_ff)
               3'd0: begin
                  sub_in = 3'd1;
               end
               default: begin
                  bld_we = 1'b1;
                  bld_wd = xmix_wd;
                  x_in   = mix_x;
                  sub_in = 3'd0;
                  if (idx_ff == 8'd0) begin
                     tmp_in = xmix_wd;
                  end
                  if (idx_ff == IDX_LAST) begin
                     phase_in = PH_WRAP;
                     idx_in   = '0;
                  end else begin
                     idx_in = idx_ff + 8'd1;
                  end
               end
            endcase
         end
         PH_WRAP: begin
            // The extra entry mirrors entry zero before the shuffle.
            bld_we   = 1'b1;
            bld_wa   = WRAP_ADDR;
            bld_wd   = tmp_ff;
            sel_in   = x_ff[7:0];
            phase_in = PH_SHUF;
            idx_in   = '0;
            sub_in   = '0;
         end
         PH_SHUF: begin
            unique case (sub_ff)
               3'd0: begin
                  bld_ra = {1'b0, idx_ff ^ sel_ff};
                  sub_in = 3'd1;
               end
               3'd1: begin
                  sel_in = rd_ff[7:0] ^ sel_ff;
                  sub_in = 3'd2;
               end
               3'd2: begin
                  bld_ra = {1'b0, sel_ff};
                  sub_in = 3'd3;
               end
               3'd3: begin
                  tmp_in = rd_ff;
                  bld_ra = {1'b0, idx_ff} + 9'd1;
                  sub_in = 3'd4;
               end
               3'd4: begin
                  bld_we = 1'b1;
                  bld_wd = tmp_ff;
                  tmp_in = rd_ff;
                  sub_in = 3'd5;
               end
               default: begin
                  // Written after entry i, so a selector equal to i ends with
                  // the following entry, as the schedule defines.
                  bld_we = 1'b1;
                  bld_wa = {1'b0, sel_ff};
                  bld_wd = tmp_ff;
                  sub_in = 3'd0;
                  if (idx_ff == IDX_LAST) begin
                     phase_in = PH_RUN;
                     idx_in   = '0;
                  end else begin
                     idx_in = idx_ff + 8'd1;
                  end
               end
            endcase
         end
         PH_RUN: begin
            phase_in = PH_RUN;
         end
         default: begin
            phase_in = PH_SEED;
            idx_in   = '0;
            sub_in   = '0;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index) inside
            CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3: begin
               key_in[csr_index[1:0]] = csr_wdata;
               phase_in = PH_SEED;
               idx_in   = '0;
               sub_in   = '0;
            end
            CSR_MODE: begin
               mode_in = csr_wdata[0];
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Cipher engine: four chained lookups, the last one overlapped with the
   // first of the next word.
   // ------------------------------------------------------------------------
   assign look      = {8'h00, s_ff[WORD_W-1:8]} ^ rd_ff;
   assign at_d      = busy_ff && (stg_ff == STG_D);
   assign out_ok    = !out_valid_ff || !rsp_stall;
   assign start     = run && in_full_ff && (!busy_ff || (at_d && out_ok));
   assign a_cur     = in_first_ff ? key_ff[0] : a_ff;
   assign d_cur     = in_first_ff ? key_ff[3] : (at_d ? look : d_ff);
   assign res       = in_data_ff ^ d_cur;
   assign feed      = mode_ff ? in_data_ff : res;
   assign s_start   = a_cur + feed;
   assign s_chain   = base + look;
   assign req_stall = !run || (in_full_ff && !start);
   assign in_accept = req_valid && !req_stall;

   always_comb begin
      case (stg_ff)
         STG_A:   base = b_ff;
         STG_B:   base = c_ff;
         default: base = d_ff;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      stg_in       = stg_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      cph_re       = 1'b0;
      cph_ra       = {1'b0, s_chain[7:0]};
      in_full_in   = in_full_ff;
      in_data_in   = in_data_ff;
      in_first_in  = in_first_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (run && busy_ff) begin
         unique case (stg_ff)
            STG_A: begin
               a_in   = look;
               s_in   = s_chain;
               stg_in = STG_B;
               cph_re = 1'b1;
            end
            STG_B: begin
               b_in   = look;
               s_in   = s_chain;
               stg_in = STG_C;
               cph_re = 1'b1;
            end
            STG_C: begin
               c_in   = look;
               s_in   = s_chain;
               stg_in = STG_D;
               cph_re = 1'b1;
            end
            default: begin
               if (out_ok) begin
                  d_in                = look;
                  busy_in             = 1'b0;
                  out_valid_in        = 1'b1;
                  out_in.result_word  = res_ff;
                  out_in.reg_a        = a_ff;
                  out_in.reg_b        = b_ff;
                  out_in.reg_c        = c_ff;
                  out_in.reg_d        = look;
               end
            end
         endcase
      end

      if (start) begin
         busy_in    = 1'b1;
         stg_in     = STG_A;
         s_in       = s_start;
         res_in     = res;
         d_in       = d_cur;
         cph_re     = 1'b1;
         cph_ra     = {1'b0, s_start[7:0]};
         in_full_in = 1'b0;
         if (in_first_ff) begin
            b_in = key_ff[1];
            c_in = key_ff[2];
         end
      end

      if (in_accept) begin
         in_full_in  = 1'b1;
         in_data_in  = req_data_word;
         in_first_in = req_first_word;
      end
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0]    <= KEY0_RST;
         key_ff[1]    <= KEY1_RST;
         key_ff[2]    <= KEY2_RST;
         key_ff[3]    <= KEY3_RST;
         mode_ff      <= 1'b1;
         phase_ff     <= PH_SEED;
         idx_ff       <= '0;
         sub_ff       <= '0;
         a_ff         <= KEY0_RST;
         b_ff         <= KEY1_RST;
         c_ff         <= KEY2_RST;
         d_ff         <= KEY3_RST;
         busy_ff      <= 1'b0;
         stg_ff       <= STG_A;
         in_full_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         sub_ff       <= sub_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         d_ff         <= d_in;
         busy_ff      <= busy_in;
         stg_ff       <= stg_in;
         in_full_ff   <= in_full_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_ff     <= hist_in;
      tmp_ff      <= tmp_in;
      x_ff        <= x_in;
      z_ff        <= z_in;
      sel_ff      <= sel_in;
      s_ff        <= s_in;
      res_ff      <= res_in;
      in_data_ff  <= in_data_in;
      in_first_ff <= in_first_in;
      out_ff      <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_word   = out_ff.result_word;
   assign rsp_running_reg_a = out_ff.reg_a;
   assign rsp_running_reg_b = out_ff.reg_b;
   assign rsp_running_reg_c = out_ff.reg_c;
   assign rsp_running_reg_d = out_ff.reg_d;

endmodule

@@ hdl/wac_checker.sv @@
// ----------------------------------------------------------------------------
// wac_checker
// Port-level checks of the word autokey stream cipher, bound to its top level.
// ----------------------------------------------------------------------------
module wac_checker
   import wac_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [WORD_W-1:0]    rsp_result_word,
   input logic [WORD_W-1:0]    rsp_running_reg_a,
   input logic [WORD_W-1:0]    rsp_running_reg_b,
   input logic [WORD_W-1:0]    rsp_running_reg_c,
   input logic [WORD_W-1:0]    rsp_running_reg_d,
   input logic                 csr_we,
   input logic [CSR_IDX_W-1:0] csr_index
);

   // A held result keeps its whole word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_word)
         && $stable(rsp_running_reg_a) && $stable(rsp_running_reg_b)
         && $stable(rsp_running_reg_c) && $stable(rsp_running_reg_d))
      else $error("result word changed while stalled");

   // The table is rebuilt after reset, so no input is taken right away.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input taken before the table was built");

   // A key write restarts the table build.
   assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_KEY0 || csr_index == CSR_KEY1
         || csr_index == CSR_KEY2 || csr_index == CSR_KEY3) |=> req_stall)
      else $error("input taken right after a key write");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind wake_autokey_stream_cipher wac_checker u_wac_checker (.*);

@@ tb/sv/wake_autokey_stream_cipher_tb.sv @@
// ----------------------------------------------------------------------------
// wake_autokey_stream_cipher_tb
// Drives words through the autokey cipher under several key and mode settings
// and compares every result word and the running registers with a predictor
// that builds its own mixing table from the key.
// ----------------------------------------------------------------------------
module wake_autokey_stream_cipher_tb;
   import wac_pkg::*;

   localparam int WATCHDOG_LIMIT = 12000;
   localparam int STREAM_WORDS   = 55;
   localparam int KEY_SETTINGS   = 6;

   localparam logic [WORD_W-1:0] SEED_WORDS [8] = '{
      32'h726A_8F3B, 32'hE69A_3B5C, 32'hD3C7_1FE5, 32'hAB3C_73D2,
      32'h4D3A_8EB3, 32'h0396_D6E8, 32'h3D4C_2F7A, 32'h9EE2_7CF3
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [WORD_W-1:0]    req_data_word;
   logic                 req_first_word;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [WORD_W-1:0]    rsp_result_word;
   logic [WORD_W-1:0]    rsp_running_reg_a;
   logic [WORD_W-1:0]    rsp_running_reg_b;
   logic [WORD_W-1:0]    rsp_running_reg_c;
   logic [WORD_W-1:0]    rsp_running_reg_d;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   // Predictor state.
   logic [WORD_W-1:0] key_words [4];
   logic              decrypt_on;
   logic [WORD_W-1:0] run_a, run_b, run_c, run_d;
   logic [WORD_W-1:0] mix_tbl [0:TBL_DEPTH-1];

   rsp_word_type cipher_words_due [$];

   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   int mismatch_count = 0;
   int idle_cycles = 0;

   wake_autokey_stream_cipher dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_word     (req_data_word),
      .req_first_word    (req_first_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_word   (rsp_result_word),
      .rsp_running_reg_a (rsp_running_reg_a),
      .rsp_running_reg_b (rsp_running_reg_b),
      .rsp_running_reg_c (rsp_running_reg_c),
      .rsp_running_reg_d (rsp_running_reg_d),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   // Key schedule: seed fill, mixing of the first entries, top-byte
   // permutation and the final shuffle.
   function automatic void build_mix_table();
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] z;
      logic [7:0]        sel;
      logic [7:0]        k;
      for (int i = 0; i < 4; i++) mix_tbl[i] = key_words[i];
      for (int i = 4; i < 256; i++) begin
         x = mix_tbl[i-4] + mix_tbl[i-1];
         mix_tbl[i] = (x >> 3) ^ SEED_WORDS[x[2:0]];
      end
      for (int i = 0; i < 23; i++) mix_tbl[i] = mix_tbl[i] + mix_tbl[i+89];
      x = mix_tbl[33];
      z = (mix_tbl[59] | 32'h0100_0001) & 32'hFF7F_FFFF;
      for (int i = 0; i < 256; i++) begin
         x = (x & 32'hFF7F_FFFF) + z;
         mix_tbl[i] = (mix_tbl[i] & 32'h00FF_FFFF) ^ x;
      end
      mix_tbl[256] = mix_tbl[0];
      sel = x[7:0];
      for (int i = 0; i < 256; i++) begin
         k = 8'(i) ^ sel;
         sel = mix_tbl[k][7:0] ^ sel;
         mix_tbl[i] = mix_tbl[sel];
         mix_tbl[sel] = mix_tbl[i+1];
      end
   endfunction

   function automatic logic [WORD_W-1:0] mix_round(input logic [WORD_W-1:0] r,
                                                   input logic [WORD_W-1:0] feed);
      logic [WORD_W-1:0] s;
      s = r + feed;
      return {8'h00, s[31:8]} ^ mix_tbl[s[7:0]];
   endfunction

   function automatic void predict_cipher_word(input logic [WORD_W-1:0] data,
                                               input logic first);
      rsp_word_type w;
      if (first) begin
         run_a = key_words[0];
         run_b = key_words[1];
         run_c = key_words[2];
         run_d = key_words[3];
      end
      w.result_word = data ^ run_d;
      run_a = mix_round(run_a, decrypt_on ? data : w.result_word);
      run_b = mix_round(run_b, run_a);
      run_c = mix_round(run_c, run_b);
      run_d = mix_round(run_d, run_c);
      w.reg_a = run_a;
      w.reg_b = run_b;
      w.reg_c = run_c;
      w.reg_d = run_d;
      cipher_words_due.push_back(w);
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatch_count++;
   endtask

   task automatic send_word(input logic [WORD_W-1:0] data, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= data;
      req_first_word <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cipher_word(data, first);
   endtask

   // Waits until every expected word is back and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (cipher_words_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx) inside
         CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3: begin
            key_words[idx[1:0]] = value;
            build_mix_table();
         end
         CSR_MODE: decrypt_on = value[0];
         default: ;
      endcase
      // A key write holds the input off while the table is rebuilt.
      repeat (4) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                           input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                           input logic mode);
      logic [WORD_W-1:0] mode_word;
      mode_word = $urandom;
      mode_word[0] = mode;
      write_csr(CSR_KEY0, k0);
      write_csr(CSR_KEY1, k1);
      write_csr(CSR_KEY2, k2);
      write_csr(CSR_KEY3, k3);
      write_csr(CSR_MODE, mode_word);
   endtask

   // Messages that start with a first word, with some words of random marking.
   task automatic send_random_stream(input int n_words);
      int                sent;
      int                len;
      logic              first;
      logic [WORD_W-1:0] data;
      sent = 0;
      while (sent < n_words) begin
         len = $urandom_range(24, 1);
         for (int j = 0; j < len && sent < n_words; j++) begin
            first = (j == 0);
            if ($urandom_range(9) == 0) first = 1'($urandom_range(1, 0));
            case ($urandom_range(15))
               0:       data = '0;
               1:       data = '1;
               default: data = $urandom;
            endcase
            send_word(data, first);
            sent++;
         end
      end
   endtask

   task automatic test_reset_key();
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'hA5A5_A5A5, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word($urandom, 1'b0);
      drain();
   endtask

   // Bits above the mode bit are set and must be ignored.
   task automatic test_encrypt_mode();
      write_csr(CSR_MODE, 32'hFFFF_FFFE);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h1234_5678, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      drain();
   endtask

   task automatic test_unknown_index();
      for (int i = int'(CSR_MODE) + 1; i < (1 << CSR_IDX_W); i++)
         write_csr(CSR_IDX_W'(i), $urandom);
      send_word(32'hDEAD_BEEF, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      drain();
   endtask

   // After a key write the running registers keep going on the new table
   // until a first word reloads them.
   task automatic test_key_extremes();
      load_key('0, '0, '0, '0, 1'b1);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h0000_0002, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      drain();
      load_key('1, '1, '1, '1, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b1);
      drain();
   endtask

   task automatic test_random_keys();
      for (int s = 0; s < KEY_SETTINGS; s++) begin
         case (s)
            0:       load_key('0, '0, '0, '0, 1'b0);
            1:       load_key('1, '1, '1, '1, 1'b1);
            2:       load_key(KEY0_RST, KEY1_RST, KEY2_RST, KEY3_RST, 1'b0);
            3:       load_key($urandom, $urandom, $urandom, $urandom, 1'b1);
            default: load_key($urandom, $urandom, $urandom, $urandom,
                              1'($urandom_range(1, 0)));
         endcase
         for (int p = 0; p < 4; p++) begin
            case (p)
               0:       begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
               1:       begin send_idle_pct = 64; rcv_stall_pct = 0;  end
               2:       begin send_idle_pct = 0;  rcv_stall_pct = 64; end
               default: begin send_idle_pct = 8;  rcv_stall_pct = 8;  end
            endcase
            send_random_stream(STREAM_WORDS);
         end
         drain();
         send_idle_pct = 0;
         rcv_stall_pct = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cipher_words_due.size() == 0) begin
            report_mismatch("unexpected result word", rsp_result_word, '0);
         end else begin
            want = cipher_words_due.pop_front();
            if (rsp_result_word !== want.result_word)
               report_mismatch("result_word", rsp_result_word, want.result_word);
            if (rsp_running_reg_a !== want.reg_a)
               report_mismatch("running_reg_a", rsp_running_reg_a, want.reg_a);
            if (rsp_running_reg_b !== want.reg_b)
               report_mismatch("running_reg_b", rsp_running_reg_b, want.reg_b);
            if (rsp_running_reg_c !== want.reg_c)
               report_mismatch("running_reg_c", rsp_running_reg_c, want.reg_c);
            if (rsp_running_reg_d !== want.reg_d)
               report_mismatch("running_reg_d", rsp_running_reg_d, want.reg_d);
         end
      end
   end

   // Register writes count as progress, since each key write is followed by
   // a long table rebuild.
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      key_words[0] = KEY0_RST;
      key_words[1] = KEY1_RST;
      key_words[2] = KEY2_RST;
      key_words[3] = KEY3_RST;
      decrypt_on = 1'b1;
      build_mix_table();
      run_a = KEY0_RST;
      run_b = KEY1_RST;
      run_c = KEY2_RST;
      run_d = KEY3_RST;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_word  <= '0;
      req_first_word <= 1'b0;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_key();
      test_encrypt_mode();
      test_unknown_index();
      test_key_extremes();
      test_random_keys();
      drain();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
